// ----- rtl/markup_token_scanner_unit_defines.svh -----
// Assertion helpers shared by the scanner RTL
`ifndef MARKUP_TOKEN_SCANNER_UNIT_DEFINES_SVH
`define MARKUP_TOKEN_SCANNER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define MTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define MTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mts_pkg.sv -----
package mts_pkg;

  localparam int unsigned ENTITY_MAX_DEF = 4;
  localparam int unsigned LINE_WIDTH_DEF = 24;
  localparam int unsigned LINE_OUT_W     = 24;
  localparam int unsigned ENT_CHARS_W    = 32;
  localparam int unsigned QUEUE_DEPTH    = 4;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_LITERAL = 3'd1,
    MODE_STRING  = 3'd2,
    MODE_ENTITY  = 3'd3,
    MODE_ESCAPE  = 3'd4,
    MODE_HEX1    = 3'd5,
    MODE_HEX2    = 3'd6
  } mode_e;

  typedef enum logic [3:0] {
    KIND_OPEN     = 4'd0,
    KIND_CLOSE    = 4'd1,
    KIND_EQUAL    = 4'd2,
    KIND_SLASH    = 4'd3,
    KIND_BANG     = 4'd4,
    KIND_QUESTION = 4'd5,
    KIND_STRING   = 4'd6,
    KIND_LITERAL  = 4'd7,
    KIND_EOF      = 4'd8
  } kind_e;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  localparam logic [ENT_CHARS_W-1:0] ENT_QUOT = 32'h7175_6F74;
  localparam logic [ENT_CHARS_W-1:0] ENT_AMP  = 32'h0061_6D70;
  localparam logic [ENT_CHARS_W-1:0] ENT_LT   = 32'h0000_6C74;
  localparam logic [ENT_CHARS_W-1:0] ENT_GT   = 32'h0000_6774;

  localparam logic [4:0] HEX_BAD = 5'd16;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } scan_in_t;

  typedef struct packed {
    logic [3:0]            token_kind;
    logic [7:0]            text_byte;
    logic                  byte_valid;
    logic                  token_last;
    logic [LINE_OUT_W-1:0] line_number;
  } scan_out_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       token_last;
  } res_t;

  typedef struct packed {
    logic                  two;
    res_t                  r0;
    res_t                  r1;
    logic [LINE_OUT_W-1:0] line;
  } cmd_t;

  typedef struct packed {
    logic  ended;
    mode_e mode;
  } front_stat_t;

  function automatic res_t mk_res(kind_e k, logic [7:0] b, logic v, logic l);
    res_t r;
    r.kind       = k;
    r.text_byte  = b;
    r.byte_valid = v;
    r.token_last = l;
    return r;
  endfunction

  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    v = HEX_BAD;
    if (c inside {[8'h30:8'h39]}) v = 5'(c - 8'h30);
    else if (c inside {[8'h61:8'h66]}) v = 5'(c - 8'h57);
    else if (c inside {[8'h41:8'h46]}) v = 5'(c - 8'h37);
    return v;
  endfunction

endpackage

// ----- rtl/mts_front.sv -----
module mts_front import mts_pkg::*; #(
  parameter int unsigned ENTITY_MAX = ENTITY_MAX_DEF,
  parameter int unsigned LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  scan_in_t    item_i,
  output logic        wr_o,
  output cmd_t        cmd_o,
  output front_stat_t stat_o
);

  localparam int unsigned LEN_W = $clog2(ENTITY_MAX + 1);

  typedef struct packed {
    logic  emit;
    res_t  res;
    mode_e mode;
    logic  nl;
  } step_t;

  function automatic step_t idle_step(logic [7:0] c);
    step_t s;
    s.emit = 1'b1;
    s.res  = mk_res(KIND_LITERAL, c, 1'b1, 1'b1);
    s.mode = MODE_IDLE;
    s.nl   = 1'b0;
    case (c)
      CH_SPACE, CH_TAB: s.emit = 1'b0;
      CH_NL: begin
        s.emit = 1'b0;
        s.nl   = 1'b1;
      end
      CH_LT:    s.res.kind = KIND_OPEN;
      CH_GT:    s.res.kind = KIND_CLOSE;
      CH_EQ:    s.res.kind = KIND_EQUAL;
      CH_SLASH: s.res.kind = KIND_SLASH;
      CH_BANG:  s.res.kind = KIND_BANG;
      CH_QMARK: s.res.kind = KIND_QUESTION;
      CH_QUOTE: begin
        s.emit = 1'b0;
        s.mode = MODE_STRING;
      end
      default: begin
        s.mode           = MODE_LITERAL;
        s.res.token_last = 1'b0;
      end
    endcase
    return s;
  endfunction

  function automatic step_t string_step(logic [7:0] c);
    step_t s;
    s.emit = 1'b0;
    s.res  = mk_res(KIND_STRING, c, 1'b1, 1'b0);
    s.mode = MODE_STRING;
    s.nl   = 1'b0;
    case (c)
      CH_QUOTE: begin
        s.emit = 1'b1;
        s.res  = mk_res(KIND_STRING, 8'h00, 1'b0, 1'b1);
        s.mode = MODE_IDLE;
      end
      CH_AMP: s.mode = MODE_ENTITY;
      CH_BSL: s.mode = MODE_ESCAPE;
      default: begin
        s.emit = 1'b1;
        s.nl   = (c == CH_NL);
      end
    endcase
    return s;
  endfunction

  mode_e                  mode_q, mode_d;
  logic [ENT_CHARS_W-1:0] chars_q, chars_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic [4:0]             hex_q, hex_d;
  logic [LINE_WIDTH-1:0]  line_q, line_d;
  logic                   ended_q, ended_d;

  logic       nl;
  logic       e0, e1;
  res_t       r0, r1;
  step_t      s;
  logic [4:0] v2;
  logic [7:0] c;
  logic [LINE_WIDTH+LINE_OUT_W-1:0] line_ext;

  assign c = item_i.in_byte;

  always_comb begin
    mode_d  = mode_q;
    chars_d = chars_q;
    len_d   = len_q;
    hex_d   = hex_q;
    ended_d = ended_q;
    nl      = 1'b0;
    e0      = 1'b0;
    e1      = 1'b0;
    r0      = '0;
    r1      = '0;
    s       = '0;
    v2      = hex_value(c);
    if (ended_q) begin
      e0 = 1'b1;
      r0 = mk_res(KIND_EOF, 8'h00, 1'b0, 1'b1);
    end else if (item_i.end_of_input) begin
      mode_d  = MODE_IDLE;
      ended_d = 1'b1;
      e0      = 1'b1;
      if (mode_q == MODE_IDLE) begin
        r0 = mk_res(KIND_EOF, 8'h00, 1'b0, 1'b1);
      end else begin
        e1 = 1'b1;
        r0 = mk_res((mode_q == MODE_LITERAL) ? KIND_LITERAL : KIND_STRING,
                    8'h00, 1'b0, 1'b1);
        r1 = mk_res(KIND_EOF, 8'h00, 1'b0, 1'b1);
      end
    end else begin
      case (mode_q)
        MODE_LITERAL: begin
          e0 = 1'b1;
          if (c inside {CH_SPACE, CH_TAB, CH_NL, CH_EQ, CH_LT, CH_GT}) begin
            r0     = mk_res(KIND_LITERAL, 8'h00, 1'b0, 1'b1);
            s      = idle_step(c);
            mode_d = s.mode;
            nl     = s.nl;
            e1     = s.emit;
            r1     = s.res;
          end else begin
            r0 = mk_res(KIND_LITERAL, c, 1'b1, 1'b0);
          end
        end
        MODE_STRING: begin
          s      = string_step(c);
          mode_d = s.mode;
          nl     = s.nl;
          e0     = s.emit;
          r0     = s.res;
          if (s.mode == MODE_ENTITY) begin
            chars_d = '0;
            len_d   = '0;
          end
        end
        MODE_ENTITY: begin
          if (c == CH_SEMI) begin
            mode_d = MODE_STRING;
            if (len_q == LEN_W'(4) && chars_q == ENT_QUOT) begin
              e0 = 1'b1;
              r0 = mk_res(KIND_STRING, CH_QUOTE, 1'b1, 1'b0);
            end else if (len_q == LEN_W'(3) && chars_q == ENT_AMP) begin
              e0 = 1'b1;
              r0 = mk_res(KIND_STRING, CH_AMP, 1'b1, 1'b0);
            end else if (len_q == LEN_W'(2) && chars_q == ENT_LT) begin
              e0 = 1'b1;
              r0 = mk_res(KIND_STRING, CH_LT, 1'b1, 1'b0);
            end else if (len_q == LEN_W'(2) && chars_q == ENT_GT) begin
              e0 = 1'b1;
              r0 = mk_res(KIND_STRING, CH_GT, 1'b1, 1'b0);
            end
          end else if (len_q >= LEN_W'(ENTITY_MAX)) begin
            s      = string_step(c);
            mode_d = s.mode;
            nl     = s.nl;
            e0     = s.emit;
            r0     = s.res;
            if (s.mode == MODE_ENTITY) begin
              chars_d = '0;
              len_d   = '0;
            end
          end else begin
            chars_d = {chars_q[ENT_CHARS_W-9:0], c};
            len_d   = len_q + LEN_W'(1);
          end
        end
        MODE_ESCAPE: begin
          mode_d = MODE_STRING;
          e0     = 1'b1;
          case (c)
            CH_LC_N: r0 = mk_res(KIND_STRING, CH_NL, 1'b1, 1'b0);
            CH_LC_T: r0 = mk_res(KIND_STRING, CH_TAB, 1'b1, 1'b0);
            CH_LC_X: begin
              e0     = 1'b0;
              mode_d = MODE_HEX1;
            end
            default: r0 = mk_res(KIND_STRING, c, 1'b1, 1'b0);
          endcase
        end
        MODE_HEX1: begin
          hex_d  = v2;
          mode_d = MODE_HEX2;
        end
        MODE_HEX2: begin
          mode_d = MODE_STRING;
          if (!hex_q[4] && !v2[4]) begin
            e0 = 1'b1;
            r0 = mk_res(KIND_STRING, {hex_q[3:0], v2[3:0]}, 1'b1, 1'b0);
          end
        end
        default: begin
          s      = idle_step(c);
          mode_d = s.mode;
          nl     = s.nl;
          e0     = s.emit;
          r0     = s.res;
        end
      endcase
    end
  end

  assign line_d   = (nl && line_q != '1) ? line_q + LINE_WIDTH'(1) : line_q;
  assign line_ext = {LINE_OUT_W'(0), line_d};

  assign wr_o      = accept_i && e0;
  assign cmd_o.two  = e1;
  assign cmd_o.r0   = r0;
  assign cmd_o.r1   = r1;
  assign cmd_o.line = line_ext[LINE_OUT_W-1:0];

  assign stat_o.ended = ended_q;
  assign stat_o.mode  = mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      chars_q <= '0;
      len_q   <= '0;
      hex_q   <= '0;
      line_q  <= LINE_WIDTH'(1);
      ended_q <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      chars_q <= chars_d;
      len_q   <= len_d;
      hex_q   <= hex_d;
      line_q  <= line_d;
      ended_q <= ended_d;
    end
  end

endmodule

// ----- rtl/mts_queue.sv -----
module mts_queue import mts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wdata_i,
  input  logic rd_i,
  output cmd_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) cnt_d = cnt_q + CNT_W'(1);
    else if (do_rd && !do_wr) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= wptr_q + PTR_W'(1);
      if (do_rd) rptr_q <= rptr_q + PTR_W'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/mts_back.sv -----
module mts_back import mts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      head_i,
  input  logic      q_empty_i,
  output logic      q_rd_o,
  output logic      empty_o,
  input  logic      pop_i,
  output scan_out_t res_o
);

  cmd_t slot_q;
  logic vld_q;
  logic idx_q;
  logic done, adv, load;
  res_t cur;

  assign done   = vld_q && pop_i && (idx_q || !slot_q.two);
  assign adv    = vld_q && pop_i && !done;
  assign load   = (!vld_q || done) && !q_empty_i;
  assign q_rd_o = load;

  assign empty_o = !vld_q;
  assign cur     = idx_q ? slot_q.r1 : slot_q.r0;

  assign res_o.token_kind  = cur.kind;
  assign res_o.text_byte   = cur.text_byte;
  assign res_o.byte_valid  = cur.byte_valid;
  assign res_o.token_last  = cur.token_last;
  assign res_o.line_number = slot_q.line;

  always_ff @(posedge clk_i) begin
    if (load) begin
      slot_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
      idx_q <= 1'b0;
    end else if (done) begin
      vld_q <= 1'b0;
    end else if (adv) begin
      idx_q <= 1'b1;
    end
  end

endmodule

// ----- rtl/markup_token_scanner_unit.sv -----
// Path: a taken input beat goes into the queue, then into the result register on the ports.
// Throughput: one input beat per cycle while the queue is not full; the result side drains
// one beat per cycle while pop is held; a beat with two results holds the drain for both.
// The four-entry queue between the scanner and the result register sets how far they drift.
// Reset: asynchronous, active low; idle mode, line count one, queue and result register empty.
`include "markup_token_scanner_unit_defines.svh"

module markup_token_scanner_unit import mts_pkg::*; #(
  parameter int unsigned ENTITY_MAX = ENTITY_MAX_DEF,
  parameter int unsigned LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  scan_in_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output scan_out_t res_o
);

  logic        in_acc;
  logic        fq_wr, fq_full, fq_empty, fq_rd;
  cmd_t        fq_wdata, fq_rdata;
  front_stat_t fstat;

  assign full   = fq_full;
  assign in_acc = push && !fq_full;

  mts_front #(
    .ENTITY_MAX(ENTITY_MAX),
    .LINE_WIDTH(LINE_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_acc),
    .item_i  (in_item_i),
    .wr_o    (fq_wr),
    .cmd_o   (fq_wdata),
    .stat_o  (fstat)
  );

  mts_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (fq_wr),
    .wdata_i(fq_wdata),
    .rd_i   (fq_rd),
    .rdata_o(fq_rdata),
    .full_o (fq_full),
    .empty_o(fq_empty)
  );

  mts_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (fq_rdata),
    .q_empty_i(fq_empty),
    .q_rd_o   (fq_rd),
    .empty_o  (empty),
    .pop_i    (pop),
    .res_o    (res_o)
  );

  `MTS_ASSERT_IMP(a_no_wr_when_full, fq_wr, !fq_full, "queue written while full")
  `MTS_ASSERT_NXT(a_eoi_latches, in_acc && in_item_i.end_of_input, fstat.ended, "end not held")
  `MTS_ASSERT_IMP(a_ended_is_idle, fstat.ended, fstat.mode == MODE_IDLE, "mode left idle at end")

endmodule

// ----- tb/sv/markup_token_scanner_unit_test.sv -----
`timescale 1ns / 1ps

module markup_token_scanner_unit_test;
  import mts_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned RANDOM_BYTES = 1900;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  scan_in_t  in_item = '0;
  logic      full;
  logic      empty;
  scan_out_t res_o;

  scan_in_t  pending_bytes[$];
  scan_out_t token_beats_q[$];
  scan_out_t step_beats[$];
  scan_out_t want;

  mode_e                     scan_mode = MODE_IDLE;
  logic [ENT_CHARS_W-1:0]    ent_chars = '0;
  int unsigned               ent_len = 0;
  logic [4:0]                hi_nibble = '0;
  logic [LINE_WIDTH_DEF-1:0] line_cnt = 1;
  logic                      input_done = 1'b0;

  int unsigned beats_in = 0;
  int unsigned total_items = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  logic        calm;

  assign calm = (beats_in >= 700) && (beats_in < 1100);

  markup_token_scanner_unit u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item),
    .empty     (empty),
    .pop       (pop),
    .res_o     (res_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Token prediction

  task automatic emit_token(kind_e k, logic [7:0] b, logic v, logic l);
    scan_out_t t;
    t.token_kind  = k;
    t.text_byte   = b;
    t.byte_valid  = v;
    t.token_last  = l;
    t.line_number = '0;
    step_beats.insert(step_beats.size(), t);
  endtask

  task automatic bump_line();
    if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
  endtask

  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    return HEX_BAD;
  endfunction

  task automatic between_tokens(logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB: ;
      CH_NL:    bump_line();
      CH_LT:    emit_token(KIND_OPEN, c, 1'b1, 1'b1);
      CH_GT:    emit_token(KIND_CLOSE, c, 1'b1, 1'b1);
      CH_EQ:    emit_token(KIND_EQUAL, c, 1'b1, 1'b1);
      CH_SLASH: emit_token(KIND_SLASH, c, 1'b1, 1'b1);
      CH_BANG:  emit_token(KIND_BANG, c, 1'b1, 1'b1);
      CH_QMARK: emit_token(KIND_QUESTION, c, 1'b1, 1'b1);
      CH_QUOTE: scan_mode = MODE_STRING;
      default: begin
        scan_mode = MODE_LITERAL;
        emit_token(KIND_LITERAL, c, 1'b1, 1'b0);
      end
    endcase
  endtask

  task automatic in_string(logic [7:0] c);
    if (c == CH_QUOTE) begin
      emit_token(KIND_STRING, 8'h00, 1'b0, 1'b1);
      scan_mode = MODE_IDLE;
    end else if (c == CH_AMP) begin
      ent_chars = '0;
      ent_len   = 0;
      scan_mode = MODE_ENTITY;
    end else if (c == CH_BSL) begin
      scan_mode = MODE_ESCAPE;
    end else begin
      if (c == CH_NL) bump_line();
      emit_token(KIND_STRING, c, 1'b1, 1'b0);
    end
  endtask

  task automatic scan_item(scan_in_t it);
    logic [7:0] c;
    logic [4:0] lo;
    c = it.in_byte;
    step_beats.delete();
    if (input_done) begin
      emit_token(KIND_EOF, 8'h00, 1'b0, 1'b1);
    end else if (it.end_of_input) begin
      if (scan_mode == MODE_LITERAL) emit_token(KIND_LITERAL, 8'h00, 1'b0, 1'b1);
      else if (scan_mode != MODE_IDLE) emit_token(KIND_STRING, 8'h00, 1'b0, 1'b1);
      emit_token(KIND_EOF, 8'h00, 1'b0, 1'b1);
      scan_mode  = MODE_IDLE;
      input_done = 1'b1;
    end else begin
      case (scan_mode)
        MODE_LITERAL: begin
          if (c inside {CH_SPACE, CH_TAB, CH_NL, CH_EQ, CH_LT, CH_GT}) begin
            emit_token(KIND_LITERAL, 8'h00, 1'b0, 1'b1);
            scan_mode = MODE_IDLE;
            between_tokens(c);
          end else begin
            emit_token(KIND_LITERAL, c, 1'b1, 1'b0);
          end
        end
        MODE_STRING: in_string(c);
        MODE_ENTITY: begin
          if (c == CH_SEMI) begin
            scan_mode = MODE_STRING;
            if (ent_len == 4 && ent_chars == ENT_QUOT)
              emit_token(KIND_STRING, CH_QUOTE, 1'b1, 1'b0);
            else if (ent_len == 3 && ent_chars == ENT_AMP)
              emit_token(KIND_STRING, CH_AMP, 1'b1, 1'b0);
            else if (ent_len == 2 && ent_chars == ENT_LT)
              emit_token(KIND_STRING, CH_LT, 1'b1, 1'b0);
            else if (ent_len == 2 && ent_chars == ENT_GT)
              emit_token(KIND_STRING, CH_GT, 1'b1, 1'b0);
          end else if (ent_len >= ENTITY_MAX_DEF) begin
            scan_mode = MODE_STRING;
            in_string(c);
          end else begin
            ent_chars = {ent_chars[ENT_CHARS_W-9:0], c};
            ent_len   = ent_len + 1;
          end
        end
        MODE_ESCAPE: begin
          scan_mode = MODE_STRING;
          if (c == CH_LC_N) emit_token(KIND_STRING, CH_NL, 1'b1, 1'b0);
          else if (c == CH_LC_T) emit_token(KIND_STRING, CH_TAB, 1'b1, 1'b0);
          else if (c == CH_LC_X) scan_mode = MODE_HEX1;
          else emit_token(KIND_STRING, c, 1'b1, 1'b0);
        end
        MODE_HEX1: begin
          hi_nibble = nibble_of(c);
          scan_mode = MODE_HEX2;
        end
        MODE_HEX2: begin
          lo = nibble_of(c);
          if (hi_nibble < HEX_BAD && lo < HEX_BAD)
            emit_token(KIND_STRING, {hi_nibble[3:0], lo[3:0]}, 1'b1, 1'b0);
          scan_mode = MODE_STRING;
        end
        default: begin
          scan_mode = MODE_IDLE;
          between_tokens(c);
        end
      endcase
    end
    foreach (step_beats[i]) begin
      step_beats[i].line_number = LINE_OUT_W'(line_cnt);
      token_beats_q.insert(token_beats_q.size(), step_beats[i]);
    end
  endtask

  // Markup generation

  task automatic add_byte(logic [7:0] b);
    scan_in_t it;
    it.in_byte      = b;
    it.end_of_input = 1'b0;
    pending_bytes.insert(pending_bytes.size(), it);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_NL;
    endcase
  endfunction

  function automatic logic [7:0] name_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 8'(8'h61 + $urandom_range(25));
    if (r < 80) return 8'(8'h41 + $urandom_range(25));
    if (r < 88) return 8'(8'h30 + $urandom_range(9));
    if (r < 94) return 8'($urandom_range(255, 128));
    return "_";
  endfunction

  function automatic logic [7:0] hex_char();
    string digits;
    digits = "0123456789abcdefABCDEF";
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return digits[$urandom_range(21)];
  endfunction

  task automatic add_blanks(int unsigned lo_n, int unsigned hi_n);
    repeat ($urandom_range(hi_n, lo_n)) add_byte(pick_blank());
  endtask

  task automatic add_name();
    repeat ($urandom_range(6, 1)) add_byte(name_char());
  endtask

  task automatic add_entity();
    int unsigned r;
    r = $urandom_range(99);
    add_byte(CH_AMP);
    if (r < 60) begin
      case ($urandom_range(3))
        0:       add_text("quot");
        1:       add_text("amp");
        2:       add_text("lt");
        default: add_text("gt");
      endcase
      add_byte(CH_SEMI);
    end else if (r < 80) begin
      repeat ($urandom_range(ENTITY_MAX_DEF, 0))
        add_byte(($urandom_range(7) == 0) ? CH_NL : name_char());
      add_byte(CH_SEMI);
    end else begin
      repeat (ENTITY_MAX_DEF + $urandom_range(3, 1))
        add_byte(($urandom_range(7) == 0) ? CH_NL : name_char());
      if ($urandom_range(1)) add_byte(CH_SEMI);
    end
  endtask

  task automatic add_escape();
    add_byte(CH_BSL);
    case ($urandom_range(7))
      0: add_byte(CH_LC_N);
      1: add_byte(CH_LC_T);
      2: add_byte(CH_BSL);
      3: add_byte(CH_QUOTE);
      4: add_byte(CH_NL);
      5: add_byte(8'($urandom_range(255)));
      default: begin
        add_byte(CH_LC_X);
        add_byte(hex_char());
        add_byte(hex_char());
      end
    endcase
  endtask

  task automatic add_quoted();
    int unsigned r;
    logic [7:0]  c;
    add_byte(CH_QUOTE);
    repeat ($urandom_range(6)) begin
      r = $urandom_range(99);
      if (r < 45) begin
        c = 8'($urandom_range(8'h7E, 8'h20));
        if (c == CH_QUOTE || c == CH_AMP || c == CH_BSL) c = "q";
        if (r < 5) c = CH_NL;
        else if (r < 10) c = 8'($urandom_range(255, 128));
        add_byte(c);
      end else if (r < 70) begin
        add_entity();
      end else begin
        add_escape();
      end
    end
    add_byte(CH_QUOTE);
  endtask

  task automatic add_tag();
    int unsigned r;
    add_byte(CH_LT);
    r = $urandom_range(9);
    if (r == 0) add_byte(CH_SLASH);
    else if (r == 1) add_byte(CH_QMARK);
    else if (r == 2) add_byte(CH_BANG);
    add_name();
    repeat ($urandom_range(3)) begin
      add_blanks(1, 2);
      add_name();
      add_blanks(0, 1);
      add_byte(CH_EQ);
      add_blanks(0, 1);
      if ($urandom_range(4) == 0) add_name();
      else add_quoted();
    end
    add_blanks(0, 1);
    r = $urandom_range(9);
    if (r == 0) add_byte(CH_SLASH);
    else if (r == 1) add_byte(CH_QMARK);
    add_byte(CH_GT);
    add_blanks(0, 2);
  endtask

  task automatic add_markup();
    int unsigned r;
    while (pending_bytes.size() < RANDOM_BYTES + 25) begin
      r = $urandom_range(99);
      if (r < 72) begin
        add_tag();
      end else if (r < 84) begin
        repeat ($urandom_range(3, 1)) begin
          add_name();
          add_blanks(1, 2);
        end
      end else if (r < 93) begin
        repeat ($urandom_range(4, 1)) add_byte(8'($urandom_range(255)));
      end else begin
        add_byte(CH_LT);
        add_name();
        add_byte(CH_EQ);
        if ($urandom_range(1)) add_quoted();
      end
    end
  endtask

  task automatic add_ending();
    scan_in_t it;
    case ($urandom_range(5))
      0: add_blanks(0, 1);
      1: add_text("ab");
      2: add_text("\"ab");
      3: add_text("\"&am");
      4: add_text("\"\\");
      default: add_text("\"\\x4");
    endcase
    it.in_byte      = 8'($urandom_range(255));
    it.end_of_input = 1'b1;
    pending_bytes.insert(pending_bytes.size(), it);
    repeat ($urandom_range(4, 2)) begin
      it.in_byte      = 8'($urandom_range(255));
      it.end_of_input = 1'($urandom_range(1));
      pending_bytes.insert(pending_bytes.size(), it);
    end
  endtask

  // Input side

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push    <= 1'b0;
      in_item <= '0;
    end else begin
      if (push && !full) begin
        scan_item(in_item);
        beats_in = beats_in + 1;
      end
      if (!push || !full) begin
        if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
          in_item <= pending_bytes.pop_front();
          push    <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result side

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (token_beats_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected beat: kind %0d byte %02h valid %0b last %0b line %0d",
                     res_o.token_kind, res_o.text_byte, res_o.byte_valid,
                     res_o.token_last, res_o.line_number);
          errors++;
        end else begin
          want = token_beats_q.pop_front();
          if (res_o.token_kind !== want.token_kind || res_o.text_byte !== want.text_byte ||
              res_o.byte_valid !== want.byte_valid || res_o.token_last !== want.token_last ||
              res_o.line_number !== want.line_number) begin
            if (errors < 10)
              $display({"beat mismatch: expected kind %0d byte %02h valid %0b last %0b ",
                        "line %0d, got kind %0d byte %02h valid %0b last %0b line %0d"},
                       want.token_kind, want.text_byte, want.byte_valid, want.token_last,
                       want.line_number, res_o.token_kind, res_o.text_byte,
                       res_o.byte_valid, res_o.token_last, res_o.line_number);
            errors++;
          end
        end
      end
      pop <= calm || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    add_text("<a=\"&lt;\\\"\\x4g\"/>!?\t\n");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_NL);
    add_markup();
    add_ending();
    total_items = pending_bytes.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_in < total_items) @(posedge clk_i);
    while (token_beats_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0 && token_beats_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
